// ===== sv/tdsc_pkg.sv =====
package tdsc_pkg;

    // field widths
    localparam int LenW   = 16;
    localparam int BlockW = 16;
    localparam int OpW    = 16;
    localparam int BaseW  = 8;
    localparam int TimerW = 11;
    localparam int CountW = 3;

    // timeouts allowed in a row before the transfer is aborted
    localparam logic [CountW-1:0] MAX_TIMEOUTS = 3'd5;

    // event kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_PACKET = 2'd2;
    localparam logic [1:0] KIND_TIMER  = 2'd3;

    // packet opcodes
    localparam logic [OpW-1:0] OP_ACK   = 16'd4;
    localparam logic [OpW-1:0] OP_ERROR = 16'd5;

    // configuration register indexes
    localparam logic CFG_SEGMENT_SIZE = 1'b0;
    localparam logic CFG_BASE_TIMEOUT = 1'b1;

    // reset values of the configuration registers
    localparam logic [LenW-1:0]  SEGMENT_SIZE_RESET = 16'd512;
    localparam logic [BaseW-1:0] BASE_TIMEOUT_RESET = 8'd5;

    // actions reported per event
    typedef enum logic [2:0] {
        ACT_REQUEST = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_RESEND  = 3'd2,
        ACT_WAIT    = 3'd3,
        ACT_DONE    = 3'd4,
        ACT_NAK     = 3'd5,
        ACT_ABORT   = 3'd6,
        ACT_IGNORED = 3'd7
    } action_t;

endpackage

// ===== sv/tftp_data_sender_control.sv =====
// Lock-step control for the sending side of a file transfer.
// Event channel: event_valid / event_stall carry one protocol event per
// transfer (kind plus its fields: start, data ready, packet received, timer
// expired). Result channel: result_valid / result_stall carry exactly one
// action per event, with block number, payload length and timer value.
// Configuration channel: cfg_valid / cfg_ready write segment_size (index 0)
// or base_timeout (index 1); cfg_ready is always high and writes are meant
// to happen only while no event is in flight.
// An event is captured in the event register, then decided and its result
// loaded into the result register once that is free. Throughput: one event
// per cycle while result_stall is low. Decision and all state updates are
// combinational between the event register and the result register, so
// back-to-back events see each other's state without any gap.
// While result_stall holds a shown result, the event register fills behind
// it, and event_stall rises only once both registers are occupied.
// Reset clears the phase to idle, the block number, length and timeout count
// to zero, and restores segment_size 512 and base_timeout 5.
module tftp_data_sender_control
    import tdsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // event channel
    input  logic              event_valid,
    output logic              event_stall,
    input  logic [1:0]        kind,
    input  logic [LenW-1:0]   option_ack_length,
    input  logic [LenW-1:0]   data_length,
    input  logic              read_failed,
    input  logic [OpW-1:0]    packet_opcode,
    input  logic [BlockW-1:0] packet_block,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output action_t           action,
    output logic [BlockW-1:0] block_out,
    output logic [LenW-1:0]   length_out,
    output logic [TimerW-1:0] timer_value,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [LenW-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_ACK  = 2'd2
    } phase_t;

    // configuration registers
    logic [LenW-1:0]   segment_size_reg;
    logic [BaseW-1:0]  base_timeout_reg;

    // event register
    logic              ev_valid_reg;
    logic [1:0]        kind_reg;
    logic [LenW-1:0]   oack_len_reg;
    logic [LenW-1:0]   data_len_reg;
    logic              failed_reg;
    logic [OpW-1:0]    opcode_reg;
    logic [BlockW-1:0] pblock_reg;

    // protocol state
    phase_t            phase_reg, phase_next;
    logic [BlockW-1:0] block_reg, block_next;
    logic [LenW-1:0]   length_reg, length_next;
    logic [CountW-1:0] count_reg, count_next;

    // result register
    logic              res_valid_reg;
    action_t           action_reg, action_next;
    logic [BlockW-1:0] block_out_reg;
    logic [LenW-1:0]   length_out_reg, length_out_next;
    logic [TimerW-1:0] timer_reg, timer_next;

    logic              res_free;
    logic              advance;
    logic              ev_take;
    logic              cfg_write;
    logic              timed;
    logic [CountW:0]   timer_factor;
    logic [BaseW+CountW:0] timer_product;

    function automatic logic [LenW-1:0] clip_len(input logic [LenW-1:0] len,
                                                 input logic [LenW-1:0] seg);
        clip_len = (len > seg) ? seg : len;
    endfunction

    // handshake control
    assign res_free    = !res_valid_reg || !result_stall;
    assign advance     = ev_valid_reg && res_free;
    assign event_stall = ev_valid_reg && !res_free;
    assign ev_take     = event_valid && !event_stall;
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;

    // event decision
    always_comb
    begin
        phase_next      = phase_reg;
        block_next      = block_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        action_next     = ACT_IGNORED;
        length_out_next = '0;
        timed           = 1'b0;
        case (kind_reg)
            KIND_START:
            begin
                count_next = '0;
                if (oack_len_reg != '0)
                begin
                    block_next      = '0;
                    length_next     = clip_len(oack_len_reg, segment_size_reg);
                    phase_next      = PH_ACK;
                    action_next     = ACT_SEND;
                    length_out_next = length_next;
                    timed           = 1'b1;
                end
                else
                begin
                    block_next  = {{(BlockW-1){1'b0}}, 1'b1};
                    length_next = '0;
                    phase_next  = PH_DATA;
                    action_next = ACT_REQUEST;
                end
            end
            KIND_DATA:
            begin
                if (phase_reg != PH_DATA)
                begin
                    action_next = ACT_IGNORED;
                end
                else if (failed_reg)
                begin
                    phase_next  = PH_IDLE;
                    action_next = ACT_NAK;
                end
                else
                begin
                    length_next     = clip_len(data_len_reg, segment_size_reg);
                    count_next      = '0;
                    phase_next      = PH_ACK;
                    action_next     = ACT_SEND;
                    length_out_next = length_next;
                    timed           = 1'b1;
                end
            end
            KIND_TIMER:
            begin
                if (phase_reg != PH_ACK)
                begin
                    action_next = ACT_IGNORED;
                end
                else if (count_reg < MAX_TIMEOUTS)
                begin
                    count_next      = count_reg + 1'b1;
                    action_next     = ACT_RESEND;
                    length_out_next = length_reg;
                    timed           = 1'b1;
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    action_next = ACT_ABORT;
                end
            end
            KIND_PACKET:
            begin
                if (phase_reg != PH_ACK)
                begin
                    action_next = ACT_IGNORED;
                end
                else
                begin
                    count_next = '0;
                    if (opcode_reg == OP_ERROR)
                    begin
                        phase_next  = PH_IDLE;
                        action_next = ACT_ABORT;
                    end
                    else if (opcode_reg != OP_ACK)
                    begin
                        phase_next  = PH_IDLE;
                        action_next = ACT_NAK;
                    end
                    else if (pblock_reg != block_reg)
                    begin
                        action_next = ACT_WAIT;
                        timed       = 1'b1;
                    end
                    else if (block_reg != '0 && length_reg != segment_size_reg)
                    begin
                        phase_next  = PH_IDLE;
                        action_next = ACT_DONE;
                    end
                    else
                    begin
                        block_next  = block_reg + 1'b1;
                        length_next = '0;
                        phase_next  = PH_DATA;
                        action_next = ACT_REQUEST;
                    end
                end
            end
            default:
            begin
                action_next = ACT_IGNORED;
            end
        endcase
    end

    // retransmit timer: base times (count + 1), using the updated count
    assign timer_factor  = {1'b0, count_next} + 1'b1;
    assign timer_product = base_timeout_reg * timer_factor;
    assign timer_next    = timed ? timer_product[TimerW-1:0] : '0;

    // state, configuration and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_size_reg <= SEGMENT_SIZE_RESET;
            base_timeout_reg <= BASE_TIMEOUT_RESET;
            ev_valid_reg     <= 1'b0;
            kind_reg         <= KIND_START;
            oack_len_reg     <= '0;
            data_len_reg     <= '0;
            failed_reg       <= 1'b0;
            opcode_reg       <= '0;
            pblock_reg       <= '0;
            phase_reg        <= PH_IDLE;
            block_reg        <= '0;
            length_reg       <= '0;
            count_reg        <= '0;
            res_valid_reg    <= 1'b0;
            action_reg       <= ACT_IGNORED;
            block_out_reg    <= '0;
            length_out_reg   <= '0;
            timer_reg        <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SEGMENT_SIZE: segment_size_reg <= cfg_data;
                    CFG_BASE_TIMEOUT: base_timeout_reg <= cfg_data[BaseW-1:0];
                    default:          segment_size_reg <= segment_size_reg;
                endcase
            end

            // event register
            if (ev_take)
            begin
                ev_valid_reg <= 1'b1;
                kind_reg     <= kind;
                oack_len_reg <= option_ack_length;
                data_len_reg <= data_length;
                failed_reg   <= read_failed;
                opcode_reg   <= packet_opcode;
                pblock_reg   <= packet_block;
            end
            else if (advance)
            begin
                ev_valid_reg <= 1'b0;
            end

            // decide the event, update state and load the result
            if (advance)
            begin
                phase_reg      <= phase_next;
                block_reg      <= block_next;
                length_reg     <= length_next;
                count_reg      <= count_next;
                res_valid_reg  <= 1'b1;
                action_reg     <= action_next;
                block_out_reg  <= block_next;
                length_out_reg <= length_out_next;
                timer_reg      <= timer_next;
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign action       = action_reg;
    assign block_out    = block_out_reg;
    assign length_out   = length_out_reg;
    assign timer_value  = timer_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_TIMEOUTS)
        else $error("timeout count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("decided event left no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        event_stall |-> (ev_valid_reg && res_valid_reg))
        else $error("event stalled with free pipeline slot");

endmodule
